// File: hw/rtl/foc_pkg.sv
// foc_pkg: shared constants, types and helper functions for the FOC current loop.
// Holds the elaboration-time sine table builder and Q16.16 saturation helpers.
// No dependencies.
`default_nettype none
package foc_pkg;

    localparam int SINE_ENTRIES    = 256;
    localparam int SIN_IDX_W       = $clog2(SINE_ENTRIES);
    localparam int DUTY_FULL_SCALE = 10000;
    localparam int DUTY_W          = 14;
    localparam int ACC_W           = 72;
    localparam int MA_W            = 36;
    localparam int MB_W            = 32;

    localparam int TWO_THIRDS_Q16  = 43691;
    localparam int INV_SQRT3_Q16   = 37837;
    localparam int SQRT3_HALF_Q16  = 56756;
    localparam int HALF_Q16        = 32768;
    localparam longint PI_HALF_Q30 = 64'sd1686629713;
    localparam longint Q30_ONE     = 64'sd1073741824;

    // ceil(2^48 / ((2n)(2n+1))) for the Taylor terms, n = 1..8
    localparam int     TERM_SHIFT = 48;
    localparam longint TERM_RECIP [8] = '{
        (64'sd1 <<< 48) / 64'sd6   + 64'sd1,
        (64'sd1 <<< 48) / 64'sd20  + 64'sd1,
        (64'sd1 <<< 48) / 64'sd42  + 64'sd1,
        (64'sd1 <<< 48) / 64'sd72  + 64'sd1,
        (64'sd1 <<< 48) / 64'sd110 + 64'sd1,
        (64'sd1 <<< 48) / 64'sd156 + 64'sd1,
        (64'sd1 <<< 48) / 64'sd210 + 64'sd1,
        (64'sd1 <<< 48) / 64'sd272 + 64'sd1
    };

    localparam logic [2:0] REG_KP_D    = 3'd0;
    localparam logic [2:0] REG_KI_D    = 3'd1;
    localparam logic [2:0] REG_KD_D    = 3'd2;
    localparam logic [2:0] REG_KP_Q    = 3'd3;
    localparam logic [2:0] REG_KI_Q    = 3'd4;
    localparam logic [2:0] REG_KD_Q    = 3'd5;
    localparam logic [2:0] REG_VLIMIT  = 3'd6;
    localparam logic [2:0] REG_PWMGAIN = 3'd7;

    typedef logic signed [17:0] sine_rom_t [SINE_ENTRIES];

    typedef struct packed {
        logic                   start;
        logic                   clear;
        logic signed [MA_W-1:0] a;
        logic signed [MB_W-1:0] b;
    } mul_req_t;

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        longint      t, f, x, s, term, sum;
        longint      quad;
        logic [95:0] prod;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            t    = longint'(k) <<< (32 - SIN_IDX_W);
            quad = (t >>> 30) & 64'sd3;
            f    = t & (Q30_ONE - 64'sd1);
            if (quad[0]) f = Q30_ONE - f;
            x    = (f * PI_HALF_Q30) >>> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 8; n++) begin
                term = (term * x) >>> 30;
                term = (term * x) >>> 30;
                prod = 96'(term) * 96'(TERM_RECIP[n-1]);
                term = longint'(prod >> TERM_SHIFT);
                if (n[0]) sum = sum - term;
                else      sum = sum + term;
            end
            if (sum < 0) sum = 0;
            s = (sum + 64'sd8192) >>> 14;
            if (s > 64'sd65536) s = 64'sd65536;
            if (quad[1]) s = -s;
            rom[k] = 18'(s);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
        if (v > $signed({{(ACC_W-31){1'b0}}, {31{1'b1}}}))
            return 32'sh7FFFFFFF;
        if (v < $signed({{(ACC_W-31){1'b1}}, {31{1'b0}}}))
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        if (v > 35'sh0_7FFF_FFFF) return 32'sh7FFFFFFF;
        if (v < -35'sh0_8000_0000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [34:0] ext35(input logic signed [31:0] v);
        return {{3{v[31]}}, v};
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/foc_smul.sv
// foc_smul: bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// 36-bit multiplicand, 32-bit two's complement multiplier, 72-bit accumulator.
// Depends on foc_pkg.
`default_nettype none
module foc_smul (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire foc_pkg::mul_req_t         req,
    output logic                           busy,
    output logic signed [foc_pkg::ACC_W-1:0] acc
);
    import foc_pkg::*;

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] mcand_reg, mcand_next;
    logic [MB_W-1:0]         mplier_reg, mplier_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        if (req.start) begin
            mcand_next  = {{(ACC_W-MA_W){req.a[MA_W-1]}}, req.a};
            mplier_next = req.b;
            cnt_next    = '0;
            busy_next   = 1'b1;
            if (req.clear) acc_next = '0;
        end else if (busy_reg) begin
            // top multiplier bit carries negative weight
            if (mplier_reg[0]) begin
                if (cnt_reg == 5'd31) acc_next = acc_reg - mcand_reg;
                else                  acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule
`default_nettype wire

// File: hw/rtl/foc_current_loop.sv
// foc_current_loop: field-oriented current loop, Clarke/Park, d/q PI(D), inverse
// transforms and PWM duty mapping, all through one bit-serial multiplier.
// Depends on foc_pkg and foc_smul.
//
// Usage:
//  s_ channel: one transfer carries three phase currents, rotor angle and the
//  d/q current targets. s_tready is high only while the block is idle.
//  m_ channel: one transfer per input with three duties and measured d/q.
//  cfg channel: register index and data; always ready. Write only while idle.
//  Sequence: 23 products, each issued, run through 32 multiplier bits, seen
//  finished and written back; m_tvalid rises from the output state that
//  follows the last write-back.
//  Throughput: one item at a time, set by the single 1-bit-per-cycle
//  multiplier; a new item is taken while the previous result still waits
//  in the output register.
//  Receiver stall: the result holds in the output register; a finished
//  computation waits until that register frees before returning to idle.
//  Reset: synchronous, active low; gains return to defaults, integrators and
//  previous errors clear, no result pending.
`default_nettype none
module foc_current_loop (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // ia[31:0], ib[63:32], ic[95:64], angle[111:96], d_tgt[143:112], q_tgt[175:144]
    input  wire logic [175:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // duty_a[13:0], duty_b[27:14], duty_c[41:28], meas_d[73:42], meas_q[105:74], 0
    output logic [111:0]      m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import foc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_WB    = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [4:0] SP_ALPHA  = 5'd0;
    localparam logic [4:0] SP_BETA   = 5'd1;
    localparam logic [4:0] SP_D0     = 5'd2;
    localparam logic [4:0] SP_D1     = 5'd3;
    localparam logic [4:0] SP_Q0     = 5'd4;
    localparam logic [4:0] SP_Q1     = 5'd5;
    localparam logic [4:0] SP_PD     = 5'd6;
    localparam logic [4:0] SP_ID     = 5'd7;
    localparam logic [4:0] SP_DD     = 5'd8;
    localparam logic [4:0] SP_PQ     = 5'd9;
    localparam logic [4:0] SP_IQ     = 5'd10;
    localparam logic [4:0] SP_DQ     = 5'd11;
    localparam logic [4:0] SP_VAL0   = 5'd12;
    localparam logic [4:0] SP_VAL1   = 5'd13;
    localparam logic [4:0] SP_VBE0   = 5'd14;
    localparam logic [4:0] SP_VBE1   = 5'd15;
    localparam logic [4:0] SP_VB0    = 5'd16;
    localparam logic [4:0] SP_VB1    = 5'd17;
    localparam logic [4:0] SP_VC0    = 5'd18;
    localparam logic [4:0] SP_VC1    = 5'd19;
    localparam logic [4:0] SP_DUTYA  = 5'd20;
    localparam logic [4:0] SP_DUTYB  = 5'd21;
    localparam logic [4:0] SP_DUTYC  = 5'd22;

    localparam logic [SIN_IDX_W-1:0] QUARTER = SIN_IDX_W'(SINE_ENTRIES / 4);

    logic [2:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;

    logic signed [31:0] kp_d_reg, ki_d_reg, kd_d_reg, kp_q_reg, ki_q_reg, kd_q_reg;
    logic [30:0]        vlim_reg, pwm_reg;

    logic signed [31:0] ia_reg, ib_reg, ic_reg, dt_reg, qt_reg;
    logic signed [17:0] sin_reg, cos_reg;
    logic signed [31:0] ial_reg, ibe_reg, md_reg, mq_reg, ed_reg, eq_reg;
    logic signed [31:0] p_reg, iv_reg, ud_reg, uq_reg;
    logic signed [31:0] val_reg, vbe_reg, vb_reg, vc_reg;
    logic [DUTY_W-1:0]  da_reg, db_reg, vc_duty_reg;
    logic signed [31:0] integ_d_reg, prev_d_reg, integ_q_reg, prev_q_reg;

    logic [111:0] m_tdata_reg;
    logic         m_tvalid_reg;

    mul_req_t                mreq;
    logic                    mbusy;
    logic signed [ACC_W-1:0] macc;

    foc_smul u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .busy    (mbusy),
        .acc     (macc)
    );

    logic [SIN_IDX_W-1:0] sin_idx;
    assign sin_idx = s_tdata[111 -: SIN_IDX_W];

    // operand selection per step
    logic signed [MA_W-1:0] op_a;
    logic signed [MB_W-1:0] op_b;
    logic                   op_clr;
    logic signed [31:0]     sin32, cos32;
    logic signed [31:0]     de_d, de_q;

    assign sin32 = {{14{sin_reg[17]}}, sin_reg};
    assign cos32 = {{14{cos_reg[17]}}, cos_reg};
    assign de_d  = sat35(ext35(ed_reg) - ext35(prev_d_reg));
    assign de_q  = sat35(ext35(eq_reg) - ext35(prev_q_reg));

    function automatic logic signed [MA_W-1:0] ea(input logic signed [31:0] v);
        return {{(MA_W-32){v[31]}}, v};
    endfunction

    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_clr = 1'b1;
        unique case (step_reg)
            SP_ALPHA: begin
                op_a = (ea(ia_reg) <<< 1) - ea(ib_reg) - ea(ic_reg);
                op_b = 32'(TWO_THIRDS_Q16);
            end
            SP_BETA:  begin op_a = ea(ib_reg) - ea(ic_reg); op_b = 32'(INV_SQRT3_Q16); end
            SP_D0:    begin op_a = ea(ial_reg); op_b = cos32; end
            SP_D1:    begin op_a = ea(ibe_reg); op_b = sin32; op_clr = 1'b0; end
            SP_Q0:    begin op_a = ea(ibe_reg); op_b = cos32; end
            SP_Q1:    begin op_a = -ea(ial_reg); op_b = sin32; op_clr = 1'b0; end
            SP_PD:    begin op_a = ea(ed_reg); op_b = kp_d_reg; end
            SP_ID:    begin op_a = ea(ed_reg); op_b = ki_d_reg; end
            SP_DD:    begin op_a = ea(de_d); op_b = kd_d_reg; end
            SP_PQ:    begin op_a = ea(eq_reg); op_b = kp_q_reg; end
            SP_IQ:    begin op_a = ea(eq_reg); op_b = ki_q_reg; end
            SP_DQ:    begin op_a = ea(de_q); op_b = kd_q_reg; end
            SP_VAL0:  begin op_a = ea(ud_reg); op_b = cos32; end
            SP_VAL1:  begin op_a = ea(uq_reg); op_b = -sin32; op_clr = 1'b0; end
            SP_VBE0:  begin op_a = ea(ud_reg); op_b = sin32; end
            SP_VBE1:  begin op_a = ea(uq_reg); op_b = cos32; op_clr = 1'b0; end
            SP_VB0:   begin op_a = ea(val_reg); op_b = -32'(HALF_Q16); end
            SP_VB1:   begin
                op_a = ea(vbe_reg); op_b = 32'(SQRT3_HALF_Q16); op_clr = 1'b0;
            end
            SP_VC0:   begin op_a = ea(val_reg); op_b = -32'(HALF_Q16); end
            SP_VC1:   begin
                op_a = ea(vbe_reg); op_b = -32'(SQRT3_HALF_Q16); op_clr = 1'b0;
            end
            SP_DUTYA: begin op_a = ea(val_reg); op_b = {1'b0, pwm_reg}; end
            SP_DUTYB: begin op_a = ea(vb_reg); op_b = {1'b0, pwm_reg}; end
            SP_DUTYC: begin op_a = ea(vc_reg); op_b = {1'b0, pwm_reg}; end
            default:  begin op_a = '0; op_b = '0; end
        endcase
    end

    assign mreq.start = (state_reg == ST_ISSUE);
    assign mreq.clear = op_clr;
    assign mreq.a     = op_a;
    assign mreq.b     = op_b;

    // write-back helpers
    logic signed [31:0]      r16, r17;
    logic signed [ACC_W-1:0] dsum;
    logic [DUTY_W-1:0]       duty;

    assign r16  = sat_acc(macc >>> 16);
    assign r17  = sat_acc(macc >>> 17);
    assign dsum = (macc >>> 16) + ACC_W'(DUTY_FULL_SCALE / 2);

    always_comb begin
        if (dsum < 0)
            duty = '0;
        else if (dsum > ACC_W'(DUTY_FULL_SCALE))
            duty = DUTY_W'(DUTY_FULL_SCALE);
        else
            duty = dsum[DUTY_W-1:0];
    end

    // PID finish: sum, clamp, back-calculation
    logic               axis_q;
    logic signed [31:0] ki_sel, u_out, i_out;
    logic signed [34:0] u_sum, lim;

    assign axis_q = (step_reg == SP_DQ);
    assign ki_sel = axis_q ? ki_q_reg : ki_d_reg;
    assign lim    = {4'b0, vlim_reg};
    assign u_sum  = ext35(p_reg) + ext35(iv_reg) + ext35(r16);

    always_comb begin
        u_out = u_sum[31:0];
        i_out = iv_reg;
        priority if (u_sum > lim) begin
            u_out = lim[31:0];
            if (ki_sel != 0) i_out = sat35(lim - ext35(p_reg) - ext35(r16));
        end else if (u_sum < -lim) begin
            u_out = 32'(-lim);
            if (ki_sel != 0) i_out = sat35(-lim - ext35(p_reg) - ext35(r16));
        end else begin
            u_out = u_sum[31:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_ISSUE;
                    step_next  = SP_ALPHA;
                end
            end
            ST_ISSUE: state_next = ST_RUN;
            ST_RUN:   if (!mbusy) state_next = ST_WB;
            ST_WB: begin
                if (step_reg == SP_DUTYC) begin
                    state_next = ST_OUT;
                end else begin
                    step_next  = step_reg + 5'd1;
                    state_next = ST_ISSUE;
                end
            end
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= SP_ALPHA;
            m_tvalid_reg <= 1'b0;
            kp_d_reg     <= 32'sd19661;
            ki_d_reg     <= '0;
            kd_d_reg     <= '0;
            kp_q_reg     <= 32'sd65536;
            ki_q_reg     <= '0;
            kd_q_reg     <= '0;
            vlim_reg     <= 31'd786432;
            pwm_reg      <= 31'd54613333;
            integ_d_reg  <= '0;
            prev_d_reg   <= '0;
            integ_q_reg  <= '0;
            prev_q_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_KP_D:    kp_d_reg <= cfg_data;
                    REG_KI_D:    ki_d_reg <= cfg_data;
                    REG_KD_D:    kd_d_reg <= cfg_data;
                    REG_KP_Q:    kp_q_reg <= cfg_data;
                    REG_KI_Q:    ki_q_reg <= cfg_data;
                    REG_KD_Q:    kd_q_reg <= cfg_data;
                    REG_VLIMIT:  vlim_reg <= cfg_data[30:0];
                    REG_PWMGAIN: pwm_reg  <= cfg_data[30:0];
                    default:     ;
                endcase
            end
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            if (state_reg == ST_WB && step_reg == SP_DD) begin
                integ_d_reg <= i_out;
                prev_d_reg  <= ed_reg;
            end
            if (state_reg == ST_WB && step_reg == SP_DQ) begin
                integ_q_reg <= i_out;
                prev_q_reg  <= eq_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            ia_reg  <= s_tdata[31:0];
            ib_reg  <= s_tdata[63:32];
            ic_reg  <= s_tdata[95:64];
            dt_reg  <= s_tdata[143:112];
            qt_reg  <= s_tdata[175:144];
            sin_reg <= SINE_ROM[sin_idx];
            cos_reg <= SINE_ROM[sin_idx + QUARTER];
        end
        if (state_reg == ST_WB) begin
            unique case (step_reg)
                SP_ALPHA: ial_reg <= r17;
                SP_BETA:  ibe_reg <= r16;
                SP_D1: begin
                    md_reg <= r16;
                    ed_reg <= sat35(ext35(dt_reg) - ext35(r16));
                end
                SP_Q1: begin
                    mq_reg <= r16;
                    eq_reg <= sat35(ext35(qt_reg) - ext35(r16));
                end
                SP_PD, SP_PQ: p_reg <= r16;
                SP_ID:    iv_reg <= sat35(ext35(integ_d_reg) + ext35(r16));
                SP_IQ:    iv_reg <= sat35(ext35(integ_q_reg) + ext35(r16));
                SP_DD:    ud_reg <= u_out;
                SP_DQ:    uq_reg <= u_out;
                SP_VAL1:  val_reg <= r16;
                SP_VBE1:  vbe_reg <= r16;
                SP_VB1:   vb_reg <= r16;
                SP_VC1:   vc_reg <= r16;
                SP_DUTYA: da_reg <= duty;
                SP_DUTYB: db_reg <= duty;
                default:  ;
            endcase
        end
        if (state_reg == ST_WB && step_reg == SP_DUTYC && (!m_tvalid_reg || m_tready))
            m_tdata_reg <= {6'b0, mq_reg, md_reg, duty, db_reg, da_reg};
        else if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready))
            m_tdata_reg <= {6'b0, mq_reg, md_reg, vc_duty_reg, db_reg, da_reg};
    end

    // duty C kept for the case where the output register is still occupied
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WB && step_reg == SP_DUTYC) vc_duty_reg <= duty;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for foc_current_loop: drives current samples, checks duties and d/q.
// Carries its own Q16.16 model of the loop (sine table, PID with anti-windup, transforms).
// Depends on foc_pkg for register indexes and the duty width.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import foc_pkg::*;

    typedef struct {
        logic signed [31:0] ia;
        logic signed [31:0] ib;
        logic signed [31:0] ic;
        logic [15:0]        angle;
        logic signed [31:0] d_tgt;
        logic signed [31:0] q_tgt;
    } sample_t;

    typedef struct {
        logic [DUTY_W-1:0]  duty_a;
        logic [DUTY_W-1:0]  duty_b;
        logic [DUTY_W-1:0]  duty_c;
        logic signed [31:0] meas_d;
        logic signed [31:0] meas_q;
    } drive_t;

    typedef struct {
        sample_t s;
        bit      fixed;     // zero currents and targets: duties at half scale, d/q zero
    } row_t;

    localparam int     N_SIN   = 256;
    localparam int     HALF    = 5000;
    localparam int     FULL    = 10000;
    localparam longint Q30     = 64'sd1073741824;
    localparam longint PIH_Q30 = 64'sd1686629713;
    localparam int     LIMIT   = 4000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [175:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    foc_current_loop i_dut (.*);

    always #4 aclk = ~aclk;

    // loop model state
    longint sin_tab [N_SIN];
    longint gain [8];
    longint d_integ, d_prev, q_integ, q_prev;
    drive_t pending_duties [$];
    int     n_errors = 0;
    int     n_samples = 0;
    int     n_writes = 0;
    int     n_checked = 0;
    int     cycles = 0;
    bit     quiet = 0;
    bit     long_hold = 0;

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return sat32((a * b) >>> 16);
    endfunction

    function automatic longint sine_entry(int k);
        longint t, f, x, term, acc, v;
        t = (longint'(k) <<< 32) / N_SIN;
        f = t & (Q30 - 1);
        if (t[30]) f = Q30 - f;
        x = (f * PIH_Q30) >>> 30;
        term = x;
        acc = x;
        for (int n = 1; n <= 8; n++) begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            acc = (n % 2 == 1) ? acc - term : acc + term;
        end
        if (acc < 0) acc = 0;
        v = (acc + 8192) >>> 14;
        if (v > 65536) v = 65536;
        return t[31] ? -v : v;
    endfunction

    function automatic longint pid(longint tgt, longint meas, longint kp, longint ki,
                                   longint kd, inout longint integ, inout longint prev);
        longint e, p, i, dv, u, lim;
        lim = gain[REG_VLIMIT];
        e = sat32(tgt - meas);
        p = qmul(kp, e);
        i = sat32(integ + qmul(ki, e));
        dv = qmul(kd, sat32(e - prev));
        u = p + i + dv;
        prev = e;
        if (u > lim) begin
            u = lim;
            if (ki != 0) i = sat32(u - p - dv);
        end else if (u < -lim) begin
            u = -lim;
            if (ki != 0) i = sat32(u - p - dv);
        end
        integ = i;
        return u;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_of(longint v);
        longint d;
        d = ((v * gain[REG_PWMGAIN]) >>> 16) + HALF;
        if (d < 0) d = 0;
        if (d > FULL) d = FULL;
        return d[DUTY_W-1:0];
    endfunction

    function automatic drive_t run_loop(sample_t s);
        drive_t r;
        longint ia, ib, ic, sn, cs, al, be, md, mq, ud, uq, val, vbe;
        int     k;
        ia = longint'(s.ia); ib = longint'(s.ib); ic = longint'(s.ic);
        k = int'(s.angle[15:8]);
        sn = sin_tab[k];
        cs = sin_tab[(k + N_SIN / 4) % N_SIN];
        al = sat32(((2 * ia - ib - ic) * 43691) >>> 17);
        be = sat32(((ib - ic) * 37837) >>> 16);
        md = sat32((al * cs + be * sn) >>> 16);
        mq = sat32((be * cs - al * sn) >>> 16);
        ud = pid(longint'(s.d_tgt), md, gain[REG_KP_D], gain[REG_KI_D], gain[REG_KD_D],
                 d_integ, d_prev);
        uq = pid(longint'(s.q_tgt), mq, gain[REG_KP_Q], gain[REG_KI_Q], gain[REG_KD_Q],
                 q_integ, q_prev);
        val = sat32((ud * cs - uq * sn) >>> 16);
        vbe = sat32((ud * sn + uq * cs) >>> 16);
        r.duty_a = duty_of(val);
        r.duty_b = duty_of(sat32((-val * 32768 + vbe * 56756) >>> 16));
        r.duty_c = duty_of(sat32((-val * 32768 - vbe * 56756) >>> 16));
        r.meas_d = md[31:0];
        r.meas_q = mq[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] amps();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return $signed($urandom_range(0, 3932160)) - 1966080;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s.ia = amps();
        s.ib = amps();
        s.ic = ($urandom_range(0, 3) == 0) ? amps() : -(s.ia + s.ib);
        s.angle = 16'($urandom);
        s.d_tgt = ($urandom_range(0, 3) == 0) ? amps() : 32'sd0;
        s.q_tgt = amps();
        return s;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_VLIMIT || idx == REG_PWMGAIN)
            gain[idx] = longint'(val & 32'h7FFF_FFFF);
        else
            gain[idx] = longint'($signed(val));
        n_writes++;
    endtask

    task automatic send(sample_t s, bit fixed);
        drive_t r;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {s.q_tgt, s.d_tgt, s.angle, s.ic, s.ib, s.ia};
        do @(posedge aclk); while (!s_tready);
        r = run_loop(s);
        if (fixed) r = '{DUTY_W'(HALF), DUTY_W'(HALF), DUTY_W'(HALF), 32'sd0, 32'sd0};
        pending_duties.push_back(r);
        n_samples++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_duties.size() != 0);
        repeat (40) @(posedge aclk);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                long_hold = 0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        drive_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.duty_a = m_tdata[13:0];
            got.duty_b = m_tdata[27:14];
            got.duty_c = m_tdata[41:28];
            got.meas_d = m_tdata[73:42];
            got.meas_q = m_tdata[105:74];
            if (pending_duties.size() == 0) begin
                $error("unexpected transfer on m_ channel");
                n_errors++;
            end else begin
                want = pending_duties.pop_front();
                n_checked++;
                if (got.duty_a !== want.duty_a) begin
                    $error("duty_a: expected %0d, got %0d", want.duty_a, got.duty_a);
                    n_errors++;
                end
                if (got.duty_b !== want.duty_b) begin
                    $error("duty_b: expected %0d, got %0d", want.duty_b, got.duty_b);
                    n_errors++;
                end
                if (got.duty_c !== want.duty_c) begin
                    $error("duty_c: expected %0d, got %0d", want.duty_c, got.duty_c);
                    n_errors++;
                end
                if (got.meas_d !== want.meas_d) begin
                    $error("measured_d_current: expected %0d, got %0d",
                           want.meas_d, got.meas_d);
                    n_errors++;
                end
                if (got.meas_q !== want.meas_q) begin
                    $error("measured_q_current: expected %0d, got %0d",
                           want.meas_q, got.meas_q);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_duties.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        row_t        plan [$];
        sample_t     z;
        logic [31:0] regs [8];
        int          per_phase;

        for (int k = 0; k < N_SIN; k++) sin_tab[k] = sine_entry(k);
        gain = '{19661, 0, 0, 65536, 0, 0, 786432, 54613333};
        d_integ = 0; d_prev = 0; q_integ = 0; q_prev = 0;

        z = '{0, 0, 0, 16'h0000, 0, 0};
        plan.push_back('{z, 1'b1});
        z.angle = 16'hFFFF;          plan.push_back('{z, 1'b1});
        z = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 16'h0000, 0, 0};
        plan.push_back('{z, 1'b0});
        z = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'h4000, 0, 0};
        plan.push_back('{z, 1'b0});
        z = '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 16'h8000, 0, 0};
        plan.push_back('{z, 1'b0});
        z = '{65536, -32768, -32768, 16'h3FFF, 32'sh7FFFFFFF, 32'sh80000000};
        plan.push_back('{z, 1'b0});
        z = '{-65536, 32768, 32768, 16'hC000, 32'sh80000000, 32'sh7FFFFFFF};
        plan.push_back('{z, 1'b0});
        z = '{0, 0, 0, 16'h2A5A, 0, 32'sh7FFFFFFF};
        plan.push_back('{z, 1'b0});
        z = '{0, 0, 0, 16'hD5A5, 0, 32'sh80000000};
        plan.push_back('{z, 1'b0});
        z = '{131072, -65536, -65536, 16'h00FF, 65536, 655360};
        plan.push_back('{z, 1'b0});
        z = '{-1, -1, -1, 16'hFF00, -1, -1};
        plan.push_back('{z, 1'b0});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) send(plan[i].s, plan[i].fixed);
        drain();

        per_phase = 140;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: regs = '{32'd98304, 32'd3277, 32'd0, 32'd98304, 32'd6554, 32'd0,
                            32'd786432, 32'd54613333};
                1: regs = '{32'd65536, 32'd1000, 32'd200, 32'd65536, 32'd1000, 32'd200,
                            32'd0, 32'd54613333};
                2: regs = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
                3: regs = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF};
                4: foreach (regs[i]) regs[i] = $urandom;
                default: begin
                    for (int i = 0; i < 6; i++)
                        regs[i] = $signed($urandom_range(0, 262144)) - 65536;
                    regs[REG_KI_D] = $urandom_range(0, 20000);
                    regs[REG_KI_Q] = $urandom_range(0, 20000);
                    regs[REG_VLIMIT] = $urandom_range(0, 24 * 65536);
                    regs[REG_PWMGAIN] = $urandom_range(0, 120000000);
                end
            endcase
            for (int i = 0; i < 8; i++) write_reg(i[2:0], regs[i]);
            cfg_valid <= 1'b0;
            @(posedge aclk);

            if (ph == 1) begin
                z = '{0, 0, 0, 16'h0000, 0, 0};
                for (int i = 0; i < 4; i++) begin
                    z.angle = 16'($urandom);
                    send(z, 1'b1);
                end
            end
            if (ph == 6) quiet = 1;
            for (int i = 0; i < per_phase; i++) begin
                if (ph == 0 && i == 20) long_hold = 1;
                send(random_sample(), 1'b0);
            end
            drain();
        end

        $display("%0d samples over 8 gain settings, %0d register writes, %0d results checked",
                 n_samples, n_writes, n_checked);
        if (n_errors == 0 && pending_duties.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
